// File: src/epsgb_pkg.sv
// ============================================================================
// Epsilon-greedy bandit package
// Shared widths, register map, default parameters and sequencer state codes.
// ============================================================================
package epsgb_pkg;

    // Default number of arms handed to the top level.
    localparam int ARMS_DEFAULT = 4;

    // Field widths.
    localparam int CMD_W    = 1;
    localparam int SAMPLE_W = 16;
    localparam int EST_W    = 32;
    localparam int CNT_W32  = 32;
    localparam int THR_W    = 17;
    localparam int ARM_OUT_W = 2;

    // Stream payload widths.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    // Configuration port.
    localparam int             APB_ADDR_W = 3;
    localparam int             APB_DATA_W = 32;
    localparam logic           REG_IDX_THR = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET = 17'd6554;

    // Command codes.
    localparam logic CMD_SELECT = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Divider runs one quotient bit per cycle over a 33-bit magnitude.
    localparam int         DIV_CNT_W = 6;
    localparam logic [5:0] DIV_LAST  = 6'd32;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_DECIDE    = 10'b00_0000_0010,
        S_SCAN_MAX  = 10'b00_0000_0100,
        S_TIE_K     = 10'b00_0000_1000,
        S_SCAN_PICK = 10'b00_0001_0000,
        S_FETCH     = 10'b00_0010_0000,
        S_LOAD      = 10'b00_0100_0000,
        S_DIV       = 10'b00_1000_0000,
        S_WRITE     = 10'b01_0000_0000,
        S_OUT       = 10'b10_0000_0000
    } state_t;

endpackage

// File: src/epsilon_greedy_bandit_core.sv
// ============================================================================
// Epsilon-greedy bandit core
// Chooses arms by epsilon-greedy selection and keeps sample-average reward
// estimates and pull counts per arm in an on-chip memory.
// ============================================================================
// One request is handled at a time and yields exactly one result. A select
// request that explores reads only the chosen arm; a greedy select scans the
// arms twice (once over every arm to find the maximum and count ties, then up
// to the tied arm it picks); an update request runs the 33-step restoring
// divider that forms (reward - estimate) / count. The arm memory has one
// registered read port, which sets the scan speed of one arm per cycle. The
// output register lets a new request be taken while the previous result still
// waits on the master side. Estimates and counts read as zero after reset
// through per-arm valid bits, so no clearing pass is needed.
module epsilon_greedy_bandit_core #(
    parameter int NUM_ARMS = epsgb_pkg::ARMS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Request stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] explore_sample, [31:16] pick_sample, [63:32] reward
    input  logic [epsgb_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] cmd
    input  logic [0:0]                          s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] chosen_arm, [33:2] arm_estimate, [65:34] arm_pulls, [71:66] zero
    output logic [epsgb_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] explored
    output logic [0:0]                          m_tuser,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [epsgb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [epsgb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [epsgb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int ARM_W  = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
    localparam int CNT_W  = $clog2(NUM_ARMS + 1);
    localparam int PROD_W = epsgb_pkg::SAMPLE_W + CNT_W;
    localparam int MEM_W  = epsgb_pkg::EST_W + epsgb_pkg::CNT_W32;
    localparam logic [CNT_W-1:0] NARM_C   = CNT_W'(NUM_ARMS);
    localparam logic [ARM_W-1:0] LAST_ARM = ARM_W'(NUM_ARMS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    epsgb_pkg::state_t state_reg, state_next;

    logic [epsgb_pkg::THR_W-1:0] thr_reg;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [NUM_ARMS-1:0]         valid_reg, valid_next;
    logic [ARM_W-1:0]            cur_arm_reg, cur_arm_next;
    logic [CNT_W-1:0]            issue_cnt_reg, issue_cnt_next;
    logic                        data_vld_reg, data_vld_next;

    logic                        cmd_reg, cmd_next;
    logic [15:0]                 esamp_reg, esamp_next;
    logic [15:0]                 psamp_reg, psamp_next;
    logic [31:0]                 reward_reg, reward_next;
    logic [ARM_W-1:0]            arm_reg, arm_next;
    logic                        explored_reg, explored_next;
    logic [31:0]                 est_reg, est_next;
    logic [31:0]                 cnt_reg, cnt_next;
    logic [ARM_W-1:0]            data_idx_reg, data_idx_next;
    logic signed [31:0]          best_reg, best_next;
    logic [CNT_W-1:0]            ties_reg, ties_next;
    logic [CNT_W-1:0]            k_reg, k_next;
    logic                        neg_reg, neg_next;
    logic [32:0]                 div_q_reg, div_q_next;
    logic [32:0]                 div_rem_reg, div_rem_next;
    logic [5:0]                  div_cnt_reg, div_cnt_next;
    logic [epsgb_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    // Arm memory: {pull count, estimate} per arm.
    logic [MEM_W-1:0] arm_mem [NUM_ARMS];
    logic [MEM_W-1:0] mem_q;
    logic             rd_en;
    logic [ARM_W-1:0] rd_addr;
    logic             mem_we;
    logic [MEM_W-1:0] mem_wdata;

    // Datapath helpers.
    logic [PROD_W-1:0]  mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic signed [31:0] scan_e;
    logic [MEM_W-1:0]   entry;
    logic [32:0]        diff;
    logic [32:0]        trial;
    logic               ge;
    logic [33:0]        qs;
    logic [33:0]        sum;
    logic [31:0]        sat;
    logic [7:0]         arm_wide;
    logic               cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[epsgb_pkg::APB_ADDR_W-1:2] == epsgb_pkg::REG_IDX_THR);
    assign prdata = (paddr[epsgb_pkg::APB_ADDR_W-1:2] == epsgb_pkg::REG_IDX_THR)
                    ? {{(epsgb_pkg::APB_DATA_W - epsgb_pkg::THR_W){1'b0}}, thr_reg}
                    : '0;

    // ------------------------------------------------------------------
    // Shared small multiplier for the explore arm and the tie index.
    // ------------------------------------------------------------------
    assign mul_b = (state_reg == epsgb_pkg::S_DECIDE) ? PROD_W'(NARM_C) : PROD_W'(ties_reg);
    assign mul_p = PROD_W'(psamp_reg) * mul_b;

    // An entry that was never written reads as zero.
    assign scan_e = valid_reg[data_idx_reg] ? $signed(mem_q[31:0]) : 32'sd0;
    assign entry  = valid_reg[arm_reg] ? mem_q : '0;

    // Update difference and one restoring divider step.
    assign diff  = {reward_reg[31], reward_reg} - {entry[31], entry[31:0]};
    assign trial = {div_rem_reg[31:0], div_q_reg[32]};
    assign ge    = trial >= {1'b0, cnt_reg};

    // Signed quotient added to the estimate, saturated to 32 bits.
    assign qs  = neg_reg ? (34'd0 - {1'b0, div_q_reg}) : {1'b0, div_q_reg};
    assign sum = {{2{est_reg[31]}}, est_reg} + qs;
    assign sat = (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) ? sum[31:0]
               : (sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign arm_wide  = {{(8 - ARM_W){1'b0}}, arm_reg};
    assign mem_wdata = {cnt_reg, sat};

    assign s_tready = (state_reg == epsgb_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg;
        valid_next     = valid_reg;
        cur_arm_next   = cur_arm_reg;
        issue_cnt_next = issue_cnt_reg;
        data_vld_next  = 1'b0;
        cmd_next       = cmd_reg;
        esamp_next     = esamp_reg;
        psamp_next     = psamp_reg;
        reward_next    = reward_reg;
        arm_next       = arm_reg;
        explored_next  = explored_reg;
        est_next       = est_reg;
        cnt_next       = cnt_reg;
        data_idx_next  = data_idx_reg;
        best_next      = best_reg;
        ties_next      = ties_reg;
        k_next         = k_reg;
        neg_next       = neg_reg;
        div_q_next     = div_q_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_cnt_reg[ARM_W-1:0];
        mem_we         = 1'b0;

        // The master side takes the pending result.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            epsgb_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = s_tuser[0];
                    esamp_next  = s_tdata[15:0];
                    psamp_next  = s_tdata[31:16];
                    reward_next = s_tdata[63:32];
                    state_next  = epsgb_pkg::S_DECIDE;
                end
            end

            // Choose the path: update, explore, or greedy scan.
            epsgb_pkg::S_DECIDE: begin
                if (cmd_reg == epsgb_pkg::CMD_UPDATE) begin
                    arm_next      = cur_arm_reg;
                    explored_next = 1'b0;
                    state_next    = epsgb_pkg::S_FETCH;
                end else if ({1'b0, esamp_reg} < thr_reg) begin
                    arm_next      = mul_p[epsgb_pkg::SAMPLE_W +: ARM_W];
                    explored_next = 1'b1;
                    state_next    = epsgb_pkg::S_FETCH;
                end else begin
                    explored_next  = 1'b0;
                    issue_cnt_next = '0;
                    state_next     = epsgb_pkg::S_SCAN_MAX;
                end
            end

            // Pass one: maximum estimate and number of arms that reach it.
            epsgb_pkg::S_SCAN_MAX: begin
                if (issue_cnt_reg < NARM_C) begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    data_vld_next  = 1'b1;
                    data_idx_next  = issue_cnt_reg[ARM_W-1:0];
                end
                if (data_vld_reg) begin
                    if (data_idx_reg == '0 || scan_e > best_reg) begin
                        best_next = scan_e;
                        ties_next = CNT_W'(1);
                    end else if (scan_e == best_reg) begin
                        ties_next = ties_reg + 1'b1;
                    end
                    if (data_idx_reg == LAST_ARM) begin
                        state_next = epsgb_pkg::S_TIE_K;
                    end
                end
            end

            // Index of the tied arm to take.
            epsgb_pkg::S_TIE_K: begin
                k_next         = mul_p[epsgb_pkg::SAMPLE_W +: CNT_W];
                issue_cnt_next = '0;
                state_next     = epsgb_pkg::S_SCAN_PICK;
            end

            // Pass two: walk to the k-th arm holding the maximum.
            epsgb_pkg::S_SCAN_PICK: begin
                if (issue_cnt_reg < NARM_C) begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    data_vld_next  = 1'b1;
                    data_idx_next  = issue_cnt_reg[ARM_W-1:0];
                end
                if (data_vld_reg && scan_e == best_reg) begin
                    if (k_reg == '0) begin
                        arm_next   = data_idx_reg;
                        state_next = epsgb_pkg::S_FETCH;
                    end else begin
                        k_next = k_reg - 1'b1;
                    end
                end
            end

            epsgb_pkg::S_FETCH: begin
                rd_en      = 1'b1;
                rd_addr    = arm_reg;
                state_next = epsgb_pkg::S_LOAD;
            end

            // Entry of the chosen arm is available.
            epsgb_pkg::S_LOAD: begin
                est_next = entry[31:0];
                cnt_next = entry[63:32];
                if (cmd_reg == epsgb_pkg::CMD_SELECT) begin
                    cur_arm_next = arm_reg;
                    state_next   = epsgb_pkg::S_OUT;
                end else begin
                    if (entry[63:32] != 32'hFFFF_FFFF) begin
                        cnt_next = entry[63:32] + 32'd1;
                    end
                    neg_next     = diff[32];
                    div_q_next   = diff[32] ? (33'd0 - diff) : diff;
                    div_rem_next = '0;
                    div_cnt_next = epsgb_pkg::DIV_LAST;
                    state_next   = epsgb_pkg::S_DIV;
                end
            end

            // One quotient bit per cycle.
            epsgb_pkg::S_DIV: begin
                div_rem_next = ge ? (trial - {1'b0, cnt_reg}) : trial;
                div_q_next   = {div_q_reg[31:0], ge};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0) begin
                    state_next = epsgb_pkg::S_WRITE;
                end
            end

            // Write the new estimate and count back.
            epsgb_pkg::S_WRITE: begin
                mem_we              = 1'b1;
                est_next            = sat;
                valid_next[arm_reg] = 1'b1;
                state_next          = epsgb_pkg::S_OUT;
            end

            // Hand the result to the output register once it is free.
            epsgb_pkg::S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, cnt_reg, est_reg, arm_wide[1:0]};
                    m_tuser_next  = explored_reg;
                    state_next    = epsgb_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = epsgb_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= epsgb_pkg::S_IDLE;
            thr_reg       <= epsgb_pkg::THR_RESET;
            m_tvalid_reg  <= 1'b0;
            valid_reg     <= '0;
            cur_arm_reg   <= '0;
            issue_cnt_reg <= '0;
            data_vld_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            valid_reg     <= valid_next;
            cur_arm_reg   <= cur_arm_next;
            issue_cnt_reg <= issue_cnt_next;
            data_vld_reg  <= data_vld_next;
            if (cfg_wr) begin
                thr_reg <= pwdata[epsgb_pkg::THR_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        esamp_reg    <= esamp_next;
        psamp_reg    <= psamp_next;
        reward_reg   <= reward_next;
        arm_reg      <= arm_next;
        explored_reg <= explored_next;
        est_reg      <= est_next;
        cnt_reg      <= cnt_next;
        data_idx_reg <= data_idx_next;
        best_reg     <= best_next;
        ties_reg     <= ties_next;
        k_reg        <= k_next;
        neg_reg      <= neg_next;
        div_q_reg    <= div_q_next;
        div_rem_reg  <= div_rem_next;
        div_cnt_reg  <= div_cnt_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // ------------------------------------------------------------------
    // Arm memory, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            arm_mem[arm_reg] <= mem_wdata;
        end
        if (rd_en) begin
            mem_q <= arm_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The divider remainder stays below the divisor.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == epsgb_pkg::S_DIV |-> div_rem_reg < {1'b0, cnt_reg})
        else $error("divider remainder not below divisor");

    // An update never divides by a zero count.
    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == epsgb_pkg::S_WRITE |-> cnt_reg != 32'd0)
        else $error("write back with zero pull count");

    // A chosen arm always lies inside the arm set.
    a_arm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == epsgb_pkg::S_FETCH |-> arm_reg <= LAST_ARM)
        else $error("chosen arm out of range");

    // A result appears only from the output state.
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == epsgb_pkg::S_OUT))
        else $error("result raised outside output state");

    // An accepted request starts the decision step.
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == epsgb_pkg::S_DECIDE)
        else $error("accepted request not decided");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Epsilon-greedy bandit core testbench
// Drives select and update requests into the core, mirrors the per-arm
// estimates, pull counts and the explore threshold in a scoreboard, and
// compares every result field by field. The sender and the receiver idle at
// random in several mixes, and the receiver once holds off long enough to
// back the core up into its input.
// ============================================================================
module tb_top;

    localparam int ARMS           = epsgb_pkg::ARMS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PRINT_LIMIT    = 200;
    localparam logic CMD_SELECT   = epsgb_pkg::CMD_SELECT;
    localparam logic CMD_UPDATE   = epsgb_pkg::CMD_UPDATE;
    localparam logic [epsgb_pkg::APB_ADDR_W-1:0] ADDR_THR =
        epsgb_pkg::APB_ADDR_W'(4 * epsgb_pkg::REG_IDX_THR);

    // One expected result of the core.
    typedef struct {
        logic [1:0]  arm;
        logic        explored;
        logic [31:0] estimate;
        logic [31:0] pulls;
    } arm_outcome_t;

    // Scoreboard: mirrors the arm state and holds the expected results in order.
    class bandit_mirror;
        logic [epsgb_pkg::THR_W-1:0] threshold;
        int               estimate [ARMS];
        int unsigned      pulls [ARMS];
        int unsigned      current_arm;
        arm_outcome_t     outcomes [$];
        int               errors;

        function new();
            threshold = epsgb_pkg::THR_RESET;
            foreach (estimate[i]) begin
                estimate[i] = 0;
                pulls[i] = 0;
            end
            current_arm = 0;
            errors = 0;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        // Greedy pick: exact maximum, then the k-th tied arm in ascending order.
        function int unsigned greedy_arm(logic [15:0] pick);
            int          best;
            int unsigned ties;
            int unsigned k;
            best = estimate[0];
            ties = 0;
            foreach (estimate[i])
                if (estimate[i] > best)
                    best = estimate[i];
            foreach (estimate[i])
                if (estimate[i] == best)
                    ties++;
            k = (32'(pick) * ties) >> 16;
            foreach (estimate[i]) begin
                if (estimate[i] == best) begin
                    if (k == 0)
                        return i;
                    k--;
                end
            end
            return 0;
        endfunction

        // Works out the result of one accepted request and queues it.
        function void note_request(logic cmd, logic [15:0] explore_s, logic [15:0] pick_s,
                                   logic [31:0] reward);
            arm_outcome_t o;
            int unsigned  arm;
            longint       moved;
            arm = current_arm;
            o.explored = 1'b0;
            if (cmd == CMD_SELECT) begin
                if ({1'b0, explore_s} < threshold) begin
                    o.explored = 1'b1;
                    arm = (32'(pick_s) * ARMS) >> 16;
                end else begin
                    arm = greedy_arm(pick_s);
                end
                current_arm = arm;
            end else begin
                // Sample-average step, quotient rounded toward zero, sum saturated.
                if (pulls[arm] != 32'hFFFF_FFFF)
                    pulls[arm]++;
                moved = longint'(estimate[arm]) +
                        (longint'(signed'(reward)) - longint'(estimate[arm])) /
                        longint'(pulls[arm]);
                if (moved > longint'(32'sh7FFF_FFFF))
                    moved = longint'(32'sh7FFF_FFFF);
                if (moved < -longint'(64'h8000_0000))
                    moved = -longint'(64'h8000_0000);
                estimate[arm] = int'(moved);
            end
            o.arm = 2'(arm);
            o.estimate = estimate[arm];
            o.pulls = pulls[arm];
            outcomes.push_back(o);
        endfunction

        task check_result(logic [1:0] arm, logic explored, logic [31:0] est,
                          logic [31:0] pulls_seen);
            arm_outcome_t o;
            if (outcomes.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            o = outcomes.pop_front();
            if (arm !== o.arm)
                report($sformatf("chosen_arm %0d, expected %0d", arm, o.arm));
            if (explored !== o.explored)
                report($sformatf("explored %0d, expected %0d", explored, o.explored));
            if (est !== o.estimate)
                report($sformatf("arm_estimate %h, expected %h", est, o.estimate));
            if (pulls_seen !== o.pulls)
                report($sformatf("arm_pulls %0d, expected %0d", pulls_seen, o.pulls));
        endtask
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // [15:0] explore_sample, [31:16] pick_sample, [63:32] reward
    logic [epsgb_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    // [0] cmd
    logic [0:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [1:0] chosen_arm, [33:2] arm_estimate, [65:34] arm_pulls, [71:66] zero
    logic [epsgb_pkg::M_TDATA_W-1:0]  m_tdata;
    // [0] explored
    logic [0:0]              m_tuser;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [epsgb_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [epsgb_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [epsgb_pkg::APB_DATA_W-1:0] prdata;
    logic                    pready;

    bandit_mirror sb;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_req = 1'b0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    epsilon_greedy_bandit_core #(.NUM_ARMS(ARMS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Handshakes are sampled mid-cycle, where all signals are settled for the
    // coming rising edge. The watchdog counts cycles with no transfer at all.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser[0], s_tdata[15:0], s_tdata[31:16], s_tdata[63:32]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[1:0], m_tuser[0], m_tdata[33:2], m_tdata[65:34]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offers one request, after a random gap, and returns at its accepting edge.
    task automatic send_req(logic cmd, logic [15:0] explore_s, logic [15:0] pick_s,
                            logic [31:0] reward);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom};
            s_tuser <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {reward, pick_s, explore_s};
        s_tuser <= cmd;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // Waits until every expected result has come back.
    task automatic wait_drain();
        while (sb.outcomes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_access(logic write, logic [31:0] data, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= ADDR_THR;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        rdata = prdata;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic readback_threshold();
        logic [31:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata !== 32'(sb.threshold))
            sb.report($sformatf("threshold reads %0d, expected %0d", rdata, sb.threshold));
    endtask

    // Write, leave the bus idle, then read the value back.
    task automatic program_threshold(logic [31:0] value);
        logic [31:0] rdata;
        apb_access(1'b1, value, rdata);
        sb.threshold = value[epsgb_pkg::THR_W-1:0];
        @(posedge aclk);
        readback_threshold();
    endtask

    // Mostly select-then-update pairs with random content; the rest is loose
    // requests. Small rewards on a coarse grid keep producing tied estimates.
    task automatic random_phase(int n_items);
        int          sent;
        int unsigned roll;
        int unsigned kind;
        logic [31:0] reward;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            kind = $urandom_range(9);
            if (kind < 3)
                reward = 32'((int'($urandom_range(6)) - 3) * 65536);
            else if (kind == 3)
                reward = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
                reward = $urandom;
            if (roll < 80) begin
                send_req(CMD_SELECT, 16'($urandom), 16'($urandom), $urandom);
                send_req(CMD_UPDATE, 16'($urandom), 16'($urandom), reward);
                sent += 2;
            end else begin
                send_req(1'($urandom), 16'($urandom), 16'($urandom), reward);
                sent += 1;
            end
        end
        s_tvalid <= 1'b0;
        wait_drain();
    endtask

    initial begin
        int unsigned phase_thr [6];
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        readback_threshold();

        // Directed requests at the reset threshold.
        send_req(CMD_UPDATE, 16'h0000, 16'h0000, 32'h7FFF_FFFF);  // update before any select
        send_req(CMD_SELECT, 16'hFFFF, 16'hFFFF, 32'h0000_0000);  // unique maximum
        send_req(CMD_UPDATE, 16'hFFFF, 16'hFFFF, 32'h8000_0000);  // widest difference
        send_req(CMD_SELECT, 16'd6554, 16'h0000, 32'hFFFF_FFFF);  // at threshold, 4-way tie
        send_req(CMD_SELECT, 16'hFFFF, 16'hFFFF, 32'h0000_0000);  // last tied arm
        send_req(CMD_SELECT, 16'hFFFF, 16'h8000, 32'h0000_0000);
        send_req(CMD_SELECT, 16'd6553, 16'h0000, 32'h0000_0000);  // just below threshold
        send_req(CMD_SELECT, 16'h0000, 16'hFFFF, 32'h0000_0000);  // explore highest arm
        send_req(CMD_UPDATE, 16'h0000, 16'h0000, 32'hFFFF_FFFD);
        send_req(CMD_UPDATE, 16'h0000, 16'h0000, 32'h0000_0000);  // odd quotient, toward zero
        send_req(CMD_UPDATE, 16'h0000, 16'h0000, 32'h8000_0000);
        send_req(CMD_SELECT, 16'h0000, 16'h4000, 32'h0000_0000);
        send_req(CMD_UPDATE, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
        send_req(CMD_SELECT, 16'hFFFF, 16'h1234, 32'h0000_0000);
        send_req(CMD_SELECT, 16'h0000, 16'hBFFF, 32'h0000_0000);
        send_req(CMD_UPDATE, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);  // two arms tied at maximum
        send_req(CMD_SELECT, 16'hFFFF, 16'h7FFF, 32'h0000_0000);
        send_req(CMD_SELECT, 16'hFFFF, 16'h8000, 32'h0000_0000);
        s_tvalid <= 1'b0;
        wait_drain();

        // Threshold extremes: never explore, always explore, and the top edge.
        program_threshold(32'd0);
        send_req(CMD_SELECT, 16'h0000, 16'hFFFF, 32'h0000_0000);
        s_tvalid <= 1'b0;
        wait_drain();
        program_threshold(32'hFFFF_FFFF);
        send_req(CMD_SELECT, 16'hFFFF, 16'h0000, 32'h0000_0000);
        s_tvalid <= 1'b0;
        wait_drain();
        program_threshold(32'd65536);
        send_req(CMD_SELECT, 16'hFFFF, 16'hC000, 32'h0000_0000);
        s_tvalid <= 1'b0;
        wait_drain();
        program_threshold(32'd65535);
        send_req(CMD_SELECT, 16'hFFFE, 16'h8000, 32'h0000_0000);
        send_req(CMD_SELECT, 16'hFFFF, 16'h8000, 32'h0000_0000);
        s_tvalid <= 1'b0;
        wait_drain();

        // Random requests over three idling mixes and six thresholds; junk
        // above the register width must be ignored.
        phase_thr = '{6554, 32768, 0, 65536, 65535, $urandom_range(65536)};
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 86 : 0;
            recv_idle_pct = (mode == 0) ? 86 : (mode == 1) ? 7 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                program_threshold(phase_thr[2 * mode + sub] | ($urandom << epsgb_pkg::THR_W));
                if (mode == 2 && sub == 1)
                    hold_req = 1'b1;
                random_phase(125);
            end
        end

        wait_drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: sim.f
src/epsgb_pkg.sv
src/epsilon_greedy_bandit_core.sv
sim/tb_top.sv
